### hdl/complex_arith_unit_top_defines.svh
// Assertion macros shared by the complex arithmetic unit.
`ifndef COMPLEX_ARITH_UNIT_TOP_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CAU_ASSERT_NOW(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error("complex_arith_unit: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CAU_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error("complex_arith_unit: next-cycle check failed");

`endif

### hdl/cau_pkg.sv
// Types, constants and helper functions of the complex arithmetic unit.
`timescale 1ns / 1ps
package cau_pkg;

    localparam int DW   = 16;                 // operand width
    localparam int FB   = 12;                 // fraction bits
    localparam int PW   = 2 * DW;             // product width
    localparam int SW   = PW + 1;             // width of a sum of two products
    localparam int QB   = DW + 1;             // quotient bits kept by the divider
    localparam int MAXS = (FB > QB) ? FB : QB;
    localparam int RW   = SW + MAXS + 1;      // divider remainder width
    localparam int DIV_LAT = QB + 2;          // divider register stages

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_INC = 3'd4;
    localparam logic [2:0] CMD_DEC = 3'd5;

    localparam logic [SW-1:0] POS_LIM = (SW'(1) << (DW - 1)) - SW'(1);
    localparam logic [SW-1:0] NEG_LIM = SW'(1) << (DW - 1);
    localparam logic [SW-1:0] Q_CAP   = SW'(1) << DW;

    typedef struct packed {
        logic          sat;
        logic [DW-1:0] val;
    } t_clip;

    // Result side band that travels alongside the divider.
    typedef struct packed {
        logic          valid;
        logic [2:0]    cmd;
        logic [DW-1:0] re;
        logic [DW-1:0] im;
        logic          sat;
        logic          dz;
        logic          eq;
        logic          sm;
        logic          lg;
    } t_side;

    function automatic logic [SW-1:0] abs_sw(input logic signed [SW-1:0] v);
        logic [SW-1:0] u;
        u = $unsigned(v);
        return v[SW-1] ? (~u + SW'(1)) : u;
    endfunction

    // Saturate a sign-magnitude value to the signed operand range.
    function automatic t_clip clip_sm(input logic neg, input logic [SW-1:0] mag);
        t_clip         r;
        logic [SW-1:0] lim;
        logic [SW-1:0] m2;
        lim   = neg ? NEG_LIM : POS_LIM;
        r.sat = mag > lim;
        m2    = r.sat ? lim : mag;
        r.val = neg ? (~m2[DW-1:0] + DW'(1)) : m2[DW-1:0];
        return r;
    endfunction

endpackage

### hdl/cau_divider.sv
// Pipelined restoring divider: quotient of |num| * 2^FB by den, one bit a stage.
`timescale 1ns / 1ps
module cau_divider (
    input  logic                          i_clk,
    input  logic signed [cau_pkg::SW-1:0] i_num,
    input  logic        [cau_pkg::SW-1:0] i_den,
    output logic        [cau_pkg::QB-1:0] o_quo,
    output logic                          o_ovf,
    output logic                          o_neg
);
    import cau_pkg::*;

    logic [SW-1:0] r_mag0;
    logic [SW-1:0] r_den0;
    logic          r_neg0;

    logic [RW-1:0] r_rem [QB+1];
    logic [SW-1:0] r_den [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic          r_ovf [QB+1];
    logic          r_neg [QB+1];

    // Sign and magnitude of the numerator.
    always_ff @(posedge i_clk) begin
        r_mag0 <= abs_sw(i_num);
        r_neg0 <= i_num[SW-1];
        r_den0 <= i_den;
    end

    // Scale the numerator and flag quotients too big for the kept bits.
    always_ff @(posedge i_clk) begin
        r_rem[0] <= RW'(r_mag0) << FB;
        r_ovf[0] <= (RW'(r_mag0) << FB) >= (RW'(r_den0) << QB);
        r_den[0] <= r_den0;
        r_neg[0] <= r_neg0;
        r_q[0]   <= '0;
    end

    for (genvar j = 0; j < QB; j++) begin : g_bit
        localparam int K = QB - 1 - j;
        logic [RW-1:0] n_try;
        logic          n_fit;
        assign n_try = RW'(r_den[j]) << K;
        assign n_fit = r_rem[j] >= n_try;
        always_ff @(posedge i_clk) begin
            r_rem[j+1] <= n_fit ? (r_rem[j] - n_try) : r_rem[j];
            r_q[j+1]   <= r_q[j] | (n_fit ? (QB'(1) << K) : '0);
            r_den[j+1] <= r_den[j];
            r_ovf[j+1] <= r_ovf[j];
            r_neg[j+1] <= r_neg[j];
        end
    end

    assign o_quo = r_q[QB];
    assign o_ovf = r_ovf[QB];
    assign o_neg = r_neg[QB];

endmodule

### hdl/complex_arith_unit_top.sv
// Top level of the complex arithmetic unit: operand, product and result pipeline.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake              Fields
//  --------  ---------  ---------------------  -------------------------------------
//  command   in         start && !busy         i_command, i_a_re/im, i_b_re/im
//  result    out        o_valid (one cycle)    o_res_re/im, o_saturated, flags
//
//  One beat is accepted in every cycle; busy stays low because nothing ever stalls.
//  Each result passes stages A to D, the side band delay line and the output register;
//  the divider, one quotient bit per stage, sets the depth of the delay line.
//  Reset is synchronous and active low; it clears only the valid bits.
//  The receiver cannot stall: the strobe lasts one cycle and the beat is then gone.
//
module complex_arith_unit_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    i_command,
    input  logic signed [cau_pkg::DW-1:0] i_a_re,
    input  logic signed [cau_pkg::DW-1:0] i_a_im,
    input  logic signed [cau_pkg::DW-1:0] i_b_re,
    input  logic signed [cau_pkg::DW-1:0] i_b_im,
    output logic                          o_valid,
    output logic signed [cau_pkg::DW-1:0] o_res_re,
    output logic signed [cau_pkg::DW-1:0] o_res_im,
    output logic                          o_saturated,
    output logic                          o_div_by_zero,
    output logic                          o_is_equal,
    output logic                          o_a_smaller,
    output logic                          o_a_larger
);
    import cau_pkg::*;
    `include "complex_arith_unit_top_defines.svh"

    assign busy = 1'b0;

    // Stage A: operand registers.
    logic                 r_a_v;
    logic [2:0]           r_a_cmd;
    logic signed [DW-1:0] r_a_ar, r_a_ai, r_a_br, r_a_bi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= start;
        end
        r_a_cmd <= i_command;
        r_a_ar  <= i_a_re;
        r_a_ai  <= i_a_im;
        r_a_br  <= i_b_re;
        r_a_bi  <= i_b_im;
    end

    // Stage B: the eight products and the linear commands.
    logic                 r_b_v;
    logic [2:0]           r_b_cmd;
    logic                 r_b_eq;
    logic signed [PW-1:0] r_b_prr, r_b_pii, r_b_pri, r_b_pir;
    logic signed [PW-1:0] r_b_sar, r_b_sai, r_b_sbr, r_b_sbi;
    logic signed [DW:0]   r_b_lre, r_b_lim;
    logic signed [DW:0]   n_lre, n_lim;
    logic signed [DW:0]   x_ar, x_ai, x_br, x_bi, x_one;

    assign x_ar  = (DW+1)'(r_a_ar);
    assign x_ai  = (DW+1)'(r_a_ai);
    assign x_br  = (DW+1)'(r_a_br);
    assign x_bi  = (DW+1)'(r_a_bi);
    assign x_one = (DW+1)'(1) << FB;

    always_comb begin
        case (r_a_cmd)
            CMD_ADD: begin
                n_lre = x_ar + x_br;
                n_lim = x_ai + x_bi;
            end
            CMD_SUB: begin
                n_lre = x_ar - x_br;
                n_lim = x_ai - x_bi;
            end
            CMD_INC: begin
                n_lre = x_ar + x_one;
                n_lim = x_ai;
            end
            CMD_DEC: begin
                n_lre = x_ar - x_one;
                n_lim = x_ai;
            end
            default: begin
                n_lre = '0;
                n_lim = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else begin
            r_b_v <= r_a_v;
        end
        r_b_cmd <= r_a_cmd;
        r_b_eq  <= (r_a_ar == r_a_br) && (r_a_ai == r_a_bi);
        r_b_prr <= PW'(r_a_ar) * PW'(r_a_br);
        r_b_pii <= PW'(r_a_ai) * PW'(r_a_bi);
        r_b_pri <= PW'(r_a_ar) * PW'(r_a_bi);
        r_b_pir <= PW'(r_a_ai) * PW'(r_a_br);
        r_b_sar <= PW'(r_a_ar) * PW'(r_a_ar);
        r_b_sai <= PW'(r_a_ai) * PW'(r_a_ai);
        r_b_sbr <= PW'(r_a_br) * PW'(r_a_br);
        r_b_sbi <= PW'(r_a_bi) * PW'(r_a_bi);
        r_b_lre <= n_lre;
        r_b_lim <= n_lim;
    end

    // Stage C: sums of products and squared magnitudes.
    logic                 r_c_v;
    logic [2:0]           r_c_cmd;
    logic                 r_c_eq;
    logic signed [SW-1:0] r_c_mre, r_c_mim, r_c_dre, r_c_dim;
    logic        [SW-1:0] r_c_ma, r_c_mb;
    logic signed [DW:0]   r_c_lre, r_c_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else begin
            r_c_v <= r_b_v;
        end
        r_c_cmd <= r_b_cmd;
        r_c_eq  <= r_b_eq;
        r_c_mre <= SW'(r_b_prr) - SW'(r_b_pii);
        r_c_mim <= SW'(r_b_pri) + SW'(r_b_pir);
        r_c_dre <= SW'(r_b_prr) + SW'(r_b_pii);
        r_c_dim <= SW'(r_b_pir) - SW'(r_b_pri);
        r_c_ma  <= $unsigned(SW'(r_b_sar) + SW'(r_b_sai));
        r_c_mb  <= $unsigned(SW'(r_b_sbr) + SW'(r_b_sbi));
        r_c_lre <= r_b_lre;
        r_c_lim <= r_b_lim;
    end

    // Stage D: results of every command except divide, and the compare flags.
    t_side         n_side;
    t_clip         n_cre, n_cim;
    logic [SW-1:0] n_mmre, n_mmim;

    assign n_mmre = abs_sw(r_c_mre) >> FB;
    assign n_mmim = abs_sw(r_c_mim) >> FB;

    always_comb begin
        n_side.valid = r_c_v;
        n_side.cmd   = r_c_cmd;
        n_side.eq    = r_c_eq;
        n_side.sm    = r_c_ma < r_c_mb;
        n_side.lg    = r_c_ma > r_c_mb;
        n_side.dz    = 1'b0;
        n_cre        = '0;
        n_cim        = '0;
        case (r_c_cmd)
            CMD_ADD, CMD_SUB, CMD_INC, CMD_DEC: begin
                n_cre = clip_sm(r_c_lre[DW], abs_sw(SW'(r_c_lre)));
                n_cim = clip_sm(r_c_lim[DW], abs_sw(SW'(r_c_lim)));
            end
            CMD_MUL: begin
                n_cre = clip_sm(r_c_mre[SW-1], n_mmre);
                n_cim = clip_sm(r_c_mim[SW-1], n_mmim);
            end
            CMD_DIV: begin
                n_side.dz = (r_c_mb == '0);
            end
            default: begin
                n_side.dz = 1'b0;
            end
        endcase
        n_side.re  = n_cre.val;
        n_side.im  = n_cim.val;
        n_side.sat = n_cre.sat | n_cim.sat;
    end

    // The side band waits in a delay line as long as the divider works.
    t_side r_dly [DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                r_dly[i].valid <= 1'b0;
            end
        end else begin
            r_dly[0] <= n_side;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    // Two divider lanes share the squared magnitude of b as divisor.
    logic [QB-1:0] w_qre, w_qim;
    logic          w_ore, w_oim, w_nre, w_nim;

    cau_divider u_div_re (
        .i_clk (i_clk),
        .i_num (r_c_dre),
        .i_den (r_c_mb),
        .o_quo (w_qre),
        .o_ovf (w_ore),
        .o_neg (w_nre)
    );

    cau_divider u_div_im (
        .i_clk (i_clk),
        .i_num (r_c_dim),
        .i_den (r_c_mb),
        .o_quo (w_qim),
        .o_ovf (w_oim),
        .o_neg (w_nim)
    );

    // Output stage: a divide takes its result from the quotients.
    t_side w_last;
    t_clip n_qre, n_qim;

    assign w_last = r_dly[DIV_LAT-1];
    assign n_qre  = clip_sm(w_nre, w_ore ? Q_CAP : SW'(w_qre));
    assign n_qim  = clip_sm(w_nim, w_oim ? Q_CAP : SW'(w_qim));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_last.valid;
        end
        if ((w_last.cmd == CMD_DIV) && !w_last.dz) begin
            o_res_re    <= $signed(n_qre.val);
            o_res_im    <= $signed(n_qim.val);
            o_saturated <= n_qre.sat | n_qim.sat;
        end else begin
            o_res_re    <= $signed(w_last.re);
            o_res_im    <= $signed(w_last.im);
            o_saturated <= w_last.sat;
        end
        o_div_by_zero <= w_last.dz;
        o_is_equal    <= w_last.eq;
        o_a_smaller   <= w_last.sm;
        o_a_larger    <= w_last.lg;
    end

    // A magnitude cannot be both below and above the other one.
    `CAU_ASSERT_NOW(a_cmp_excl, o_valid, !(o_a_smaller && o_a_larger))
    // A zero divisor yields a clean zero result.
    `CAU_ASSERT_NOW(a_dz_zero, o_valid && o_div_by_zero,
                    (o_res_re == '0) && (o_res_im == '0) && !o_saturated)
    // Equal operands compare as neither smaller nor larger.
    `CAU_ASSERT_NOW(a_eq_cmp, o_valid && o_is_equal, !o_a_smaller && !o_a_larger)
    // The strobe of the side band feeding the output register shows on o_valid in the next cycle.
    `CAU_ASSERT_NEXT(a_strobe, w_last.valid, o_valid)

endmodule
